// ===== hw/rtl/segment_pair_relation_classifier_unit_defines.svh =====
// ---------------------------------------------------------------------------
// segment pair relation classifier assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_RELATION_CLASSIFIER_UNIT_DEFINES_SVH
`define SEGMENT_PAIR_RELATION_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sprc_pkg.sv =====
// ---------------------------------------------------------------------------
// sprc_pkg
// shared constants and types of the segment pair relation classifier
// ---------------------------------------------------------------------------
package sprc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int TOL_WIDTH       = 16;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
	localparam int OUT_TDATA_W     = 8;

	typedef enum logic [1:0] {
		REL_DISJOINT = 2'd0,
		REL_TOUCH    = 2'd1,
		REL_OVERLAP  = 2'd2,
		REL_CROSSING = 2'd3
	} rel_t;

	typedef struct packed {
		logic connected;
		rel_t relation;
	} res_t;

endpackage

// ===== hw/rtl/sprc_prod.sv =====
// ---------------------------------------------------------------------------
// sprc_prod
// edge differences and the eight cross product terms, the terms registered
// ---------------------------------------------------------------------------
module sprc_prod #(
	parameter int COORD_WIDTH = sprc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic [8*COORD_WIDTH-1:0]                  crd,
	output logic [7:0][2*(COORD_WIDTH+1)-1:0]         pp_s2
);
	import sprc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int D  = CW + 1;
	localparam int P  = 2 * D;

	logic signed [CW-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
	logic signed [D-1:0]  a_dx, a_dy, b_dx, b_dy;
	logic signed [D-1:0]  b0a_dx, b0a_dy, b1a_dx, b1a_dy;
	logic signed [D-1:0]  a0b_dx, a0b_dy, a1b_dx, a1b_dy;
	logic signed [P-1:0]  prod [8];

	assign a0x = $signed(crd[0*CW +: CW]);
	assign a0y = $signed(crd[1*CW +: CW]);
	assign a1x = $signed(crd[2*CW +: CW]);
	assign a1y = $signed(crd[3*CW +: CW]);
	assign b0x = $signed(crd[4*CW +: CW]);
	assign b0y = $signed(crd[5*CW +: CW]);
	assign b1x = $signed(crd[6*CW +: CW]);
	assign b1y = $signed(crd[7*CW +: CW]);

	assign a_dx   = D'(a1x) - D'(a0x);
	assign a_dy   = D'(a1y) - D'(a0y);
	assign b_dx   = D'(b1x) - D'(b0x);
	assign b_dy   = D'(b1y) - D'(b0y);
	assign b0a_dx = D'(b0x) - D'(a0x);
	assign b0a_dy = D'(b0y) - D'(a0y);
	assign b1a_dx = D'(b1x) - D'(a0x);
	assign b1a_dy = D'(b1y) - D'(a0y);
	assign a0b_dx = D'(a0x) - D'(b0x);
	assign a0b_dy = D'(a0y) - D'(b0y);
	assign a1b_dx = D'(a1x) - D'(b0x);
	assign a1b_dy = D'(a1y) - D'(b0y);

	// terms of the cross products for b0, b1 against a and a0, a1 against b
	assign prod[0] = P'(a_dx) * P'(b0a_dy);
	assign prod[1] = P'(a_dy) * P'(b0a_dx);
	assign prod[2] = P'(a_dx) * P'(b1a_dy);
	assign prod[3] = P'(a_dy) * P'(b1a_dx);
	assign prod[4] = P'(b_dx) * P'(a0b_dy);
	assign prod[5] = P'(b_dy) * P'(a0b_dx);
	assign prod[6] = P'(b_dx) * P'(a1b_dy);
	assign prod[7] = P'(b_dy) * P'(a1b_dx);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				pp_s2[i] <= prod[i];
			end
		end
	end

endmodule

// ===== hw/rtl/sprc_classify.sv =====
// ---------------------------------------------------------------------------
// sprc_classify
// tolerance compares and relation decision from registered cross terms
// ---------------------------------------------------------------------------
module sprc_classify #(
	parameter int COORD_WIDTH = sprc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = sprc_pkg::FRAC_BITS_DEF
) (
	input  logic [8*COORD_WIDTH-1:0]              crd,
	input  logic [7:0][2*(COORD_WIDTH+1)-1:0]     pp,
	input  logic [sprc_pkg::TOL_WIDTH-1:0]        tol,
	input  logic                                  junction_present,
	output sprc_pkg::res_t                        res
);
	import sprc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int D  = CW + 1;
	localparam int P  = 2 * D;
	localparam int C  = P + 1;
	localparam int TF = TOL_WIDTH + FRAC_BITS + 1;
	localparam int XW = ((C > TF) ? C : TF) + 1;
	localparam int EW = ((D > TOL_WIDTH) ? D : TOL_WIDTH) + 2;

	function automatic logic signed [EW-1:0] ext(input logic [CW-1:0] v);
		return EW'($signed(v));
	endfunction

	function automatic logic near_eq(input logic signed [EW-1:0] a,
	                                 input logic signed [EW-1:0] b,
	                                 input logic signed [EW-1:0] t);
		return ((a - b) <= t) && ((b - a) <= t);
	endfunction

	function automatic logic signed [EW-1:0] smin(input logic signed [EW-1:0] a,
	                                              input logic signed [EW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [EW-1:0] smax(input logic signed [EW-1:0] a,
	                                              input logic signed [EW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic in_range(input logic signed [EW-1:0] v,
	                                  input logic signed [EW-1:0] a,
	                                  input logic signed [EW-1:0] b,
	                                  input logic signed [EW-1:0] t);
		return ((smin(a, b) - t) <= v) && (v <= (smax(a, b) + t));
	endfunction

	function automatic logic signed [EW-1:0] sabs(input logic signed [EW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	logic signed [EW-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
	logic signed [EW-1:0] tol_e;
	logic [XW-1:0]        tolc_u;
	logic signed [XW-1:0] tolc, ntolc;
	logic signed [XW-1:0] cr [4];
	logic [3:0]           nz, ab, be;
	logic                 ap, bp, pts_same;
	logic                 on_a0, on_a1, on_b0, on_b1;
	logic                 colin, ux, col_disj, col_touch, crossing;
	logic signed [EW-1:0] p0, p1, q0, q1, lo, hi;
	rel_t                 rel;

	assign a0x = ext(crd[0*CW +: CW]);
	assign a0y = ext(crd[1*CW +: CW]);
	assign a1x = ext(crd[2*CW +: CW]);
	assign a1y = ext(crd[3*CW +: CW]);
	assign b0x = ext(crd[4*CW +: CW]);
	assign b0y = ext(crd[5*CW +: CW]);
	assign b1x = ext(crd[6*CW +: CW]);
	assign b1y = ext(crd[7*CW +: CW]);

	assign tol_e  = $signed(EW'(tol));
	assign tolc_u = XW'(tol) << FRAC_BITS;
	assign tolc   = $signed(tolc_u);
	assign ntolc  = -tolc;

	// order: b0 and b1 against a, then a0 and a1 against b
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cr[i] = XW'($signed(pp[2*i])) - XW'($signed(pp[2*i+1]));
			nz[i] = (cr[i] >= ntolc) && (cr[i] <= tolc);
			ab[i] = cr[i] > tolc;
			be[i] = cr[i] < ntolc;
		end
	end

	assign ap       = near_eq(a0x, a1x, tol_e) && near_eq(a0y, a1y, tol_e);
	assign bp       = near_eq(b0x, b1x, tol_e) && near_eq(b0y, b1y, tol_e);
	assign pts_same = near_eq(a0x, b0x, tol_e) && near_eq(a0y, b0y, tol_e);

	assign on_a0 = nz[2] && in_range(a0x, b0x, b1x, tol_e) && in_range(a0y, b0y, b1y, tol_e);
	assign on_a1 = nz[3] && in_range(a1x, b0x, b1x, tol_e) && in_range(a1y, b0y, b1y, tol_e);
	assign on_b0 = nz[0] && in_range(b0x, a0x, a1x, tol_e) && in_range(b0y, a0y, a1y, tol_e);
	assign on_b1 = nz[1] && in_range(b1x, a0x, a1x, tol_e) && in_range(b1y, a0y, a1y, tol_e);

	// collinear pairs: overlap measured on the dominant axis of segment a
	assign colin     = nz[0] && nz[1];
	assign ux        = sabs(a1x - a0x) >= sabs(a1y - a0y);
	assign p0        = ux ? a0x : a0y;
	assign p1        = ux ? a1x : a1y;
	assign q0        = ux ? b0x : b0y;
	assign q1        = ux ? b1x : b1y;
	assign lo        = smax(smin(p0, p1), smin(q0, q1));
	assign hi        = smin(smax(p0, p1), smax(q0, q1));
	assign col_disj  = hi < (lo - tol_e);
	assign col_touch = near_eq(lo, hi, tol_e);

	assign crossing = ((be[0] && ab[1]) || (ab[0] && be[1])) &&
	                  ((be[2] && ab[3]) || (ab[2] && be[3]));

	always_comb begin
		priority if (ap && bp) begin
			rel = pts_same ? REL_TOUCH : REL_DISJOINT;
		end else if (ap) begin
			rel = on_a0 ? REL_TOUCH : REL_DISJOINT;
		end else if (bp) begin
			rel = on_b0 ? REL_TOUCH : REL_DISJOINT;
		end else if (colin) begin
			rel = col_disj ? REL_DISJOINT : (col_touch ? REL_TOUCH : REL_OVERLAP);
		end else if (on_a0 || on_a1 || on_b0 || on_b1) begin
			rel = REL_TOUCH;
		end else if (crossing) begin
			rel = REL_CROSSING;
		end else begin
			rel = REL_DISJOINT;
		end
	end

	always_comb begin
		res.relation = rel;
		unique case (rel)
			REL_TOUCH, REL_OVERLAP: res.connected = 1'b1;
			REL_CROSSING:           res.connected = junction_present;
			default:                res.connected = 1'b0;
		endcase
	end

endmodule

// ===== hw/rtl/segment_pair_relation_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// segment_pair_relation_classifier_unit
// classifies a pair of 2-d segments as disjoint, touch, overlap or crossing
// ---------------------------------------------------------------------------
// usage: one segment pair enters per s_tvalid/s_tready transaction and one
// result leaves per m_tvalid/m_tready transaction, in order.
// s_tdata holds the eight signed coordinates, first segment start x in the
// lowest bits, then the junction flag above them. m_tdata holds the relation
// code in bits [1:0] and the connect flag in bit 2.
// m_tvalid rises once the pair has passed the input register, the register
// after the eight cross product multipliers, and the result register.
// throughput is one pair per cycle while the receiver takes each result,
// every stage then advancing each cycle.
// when the receiver stalls, the result register holds and the stages behind
// it keep filling; s_tready drops only once all three stages hold a pair.
// the tolerance is written over cfg_valid/cfg_ready/cfg_data, always ready;
// write it only while no pair is in flight.
// reset empties the pipeline and sets the tolerance to one lsb.
// ---------------------------------------------------------------------------
`include "segment_pair_relation_classifier_unit_defines.svh"

module segment_pair_relation_classifier_unit #(
	parameter int COORD_WIDTH = sprc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = sprc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y, second_start_x,
	// second_start_y, second_end_x, second_end_y, junction_present, zero pad
	input  logic [8*COORD_WIDTH+7:0]              s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// relation, connected, zero pad
	output logic [sprc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sprc_pkg::TOL_WIDTH-1:0]        cfg_data
);
	import sprc_pkg::*;

	localparam int CRD_W = 8 * COORD_WIDTH;
	localparam int P     = 2 * (COORD_WIDTH + 1);

	logic                  v_s1, v_s2;
	logic [CRD_W-1:0]      crd_s1, crd_s2;
	logic                  junc_s1, junc_s2;
	logic [7:0][P-1:0]     pp_s2;
	logic                  out_valid_q;
	res_t                  out_res_q;
	res_t                  res;
	logic [TOL_WIDTH-1:0]  tol_q;
	logic                  rdy1, rdy2, rdy3;

	assign rdy3     = !out_valid_q || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			crd_s1  <= s_tdata[CRD_W-1:0];
			junc_s1 <= s_tdata[CRD_W];
		end
		if (v_s1 && rdy2) begin
			crd_s2  <= crd_s1;
			junc_s2 <= junc_s1;
		end
		if (v_s2 && rdy3) begin
			out_res_q <= res;
		end
	end

	sprc_prod #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prod (
		.clk  (clk),
		.en   (v_s1 && rdy2),
		.crd  (crd_s1),
		.pp_s2(pp_s2)
	);

	sprc_classify #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_classify (
		.crd             (crd_s2),
		.pp              (pp_s2),
		.tol             (tol_q),
		.junction_present(junc_s2),
		.res             (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_res_q.connected, out_res_q.relation});

	`SPRC_ASSERT_IMP(a_ready_when_out_empty, clk, arst_n, !out_valid_q, s_tready, "input stalled with empty result register")
	`SPRC_ASSERT_NXT(a_s2_drains, clk, arst_n, v_s2 && !out_valid_q, out_valid_q, "product stage did not move to result register")
	`SPRC_ASSERT_IMP(a_join_connected, clk, arst_n, out_valid_q && (out_res_q.relation == REL_TOUCH || out_res_q.relation == REL_OVERLAP), out_res_q.connected, "touch or overlap not connected")
	`SPRC_ASSERT_IMP(a_disjoint_open, clk, arst_n, out_valid_q && out_res_q.relation == REL_DISJOINT, !out_res_q.connected, "disjoint pair marked connected")

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment pair relation classifier: segment
// pairs go in over the input stream, an independent predictor works out the
// relation and connect flag of each accepted pair, and every output
// transaction is compared with the oldest prediction. directed corner pairs
// come first, then random point, collinear, joined and free pairs under
// several tolerances and several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sprc_pkg::*;

	localparam int CW       = COORD_WIDTH_DEF;
	localparam int FB       = FRAC_BITS_DEF;
	localparam int PIPE_LAT = 3;
	localparam int MAXC     = (1 << (CW - 1)) - 1;
	localparam int MINC     = -(1 << (CW - 1));

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [6:0] pad;
		logic       junction_present;
		coord_t     second_end_y;
		coord_t     second_end_x;
		coord_t     second_start_y;
		coord_t     second_start_x;
		coord_t     first_end_y;
		coord_t     first_end_x;
		coord_t     first_start_y;
		coord_t     first_start_x;
	} pair_item_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
	} point_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// first_start_x, first_start_y, first_end_x, first_end_y, second_start_x,
	// second_start_y, second_end_x, second_end_y, junction_present, zero pad
	logic [8*CW+7:0]        s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// relation, connected, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [TOL_WIDTH-1:0]   cfg_data = '0;

	logic [TOL_WIDTH-1:0]   tol_setting = TOL_RESET;
	res_t                   pending_results [$];
	int                     fail_count = 0;
	int                     result_count = 0;
	int                     send_idle_pct = 0;
	int                     sink_stall_pct = 0;

	segment_pair_relation_classifier_unit #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("FAIL segment_pair_relation_classifier_unit");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint labs(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic longint cross_at(point_t o, point_t a, point_t b);
		return (a.x - o.x) * (b.y - o.y) - (a.y - o.y) * (b.x - o.x);
	endfunction

	function automatic logic cross_flat(longint c);
		longint t;
		t = tol_setting;
		t = t << FB;
		return (c >= -t) && (c <= t);
	endfunction

	function automatic logic cross_pos(longint c);
		longint t;
		t = tol_setting;
		t = t << FB;
		return c > t;
	endfunction

	function automatic logic cross_neg(longint c);
		longint t;
		t = tol_setting;
		t = t << FB;
		return c < -t;
	endfunction

	function automatic logic coord_close(longint a, longint b);
		longint t;
		t = tol_setting;
		return labs(a - b) <= t;
	endfunction

	function automatic logic points_close(point_t a, point_t b);
		return coord_close(a.x, b.x) && coord_close(a.y, b.y);
	endfunction

	function automatic logic in_span(longint v, longint a, longint b);
		longint t;
		t = tol_setting;
		return (lmin(a, b) - t <= v) && (v <= lmax(a, b) + t);
	endfunction

	function automatic logic lies_on(point_t p, point_t s, point_t e);
		return cross_flat(cross_at(s, e, p)) && in_span(p.x, s.x, e.x) &&
			in_span(p.y, s.y, e.y);
	endfunction

	function automatic logic straddles(longint c0, longint c1);
		return (cross_neg(c0) && cross_pos(c1)) || (cross_pos(c0) && cross_neg(c1));
	endfunction

	function automatic res_t classify_segments(pair_item_t it);
		point_t a0, a1, b0, b1;
		longint t, cb0, cb1, ca0, ca1, p0, p1, q0, q1, lo, hi;
		logic   ap, bp, ux;
		rel_t   rel;
		res_t   r;
		t = tol_setting;
		a0.x = it.first_start_x;  a0.y = it.first_start_y;
		a1.x = it.first_end_x;    a1.y = it.first_end_y;
		b0.x = it.second_start_x; b0.y = it.second_start_y;
		b1.x = it.second_end_x;   b1.y = it.second_end_y;
		ap = points_close(a0, a1);
		bp = points_close(b0, b1);
		if (ap && bp) begin
			rel = points_close(a0, b0) ? REL_TOUCH : REL_DISJOINT;
		end else if (ap) begin
			rel = lies_on(a0, b0, b1) ? REL_TOUCH : REL_DISJOINT;
		end else if (bp) begin
			rel = lies_on(b0, a0, a1) ? REL_TOUCH : REL_DISJOINT;
		end else begin
			cb0 = cross_at(a0, a1, b0);
			cb1 = cross_at(a0, a1, b1);
			ca0 = cross_at(b0, b1, a0);
			ca1 = cross_at(b0, b1, a1);
			if (cross_flat(cb0) && cross_flat(cb1)) begin
				ux = labs(a1.x - a0.x) >= labs(a1.y - a0.y);
				p0 = ux ? a0.x : a0.y;
				p1 = ux ? a1.x : a1.y;
				q0 = ux ? b0.x : b0.y;
				q1 = ux ? b1.x : b1.y;
				lo = lmax(lmin(p0, p1), lmin(q0, q1));
				hi = lmin(lmax(p0, p1), lmax(q0, q1));
				if (hi < lo - t)
					rel = REL_DISJOINT;
				else if (coord_close(lo, hi))
					rel = REL_TOUCH;
				else
					rel = REL_OVERLAP;
			end else if (lies_on(a0, b0, b1) || lies_on(a1, b0, b1) ||
					lies_on(b0, a0, a1) || lies_on(b1, a0, a1)) begin
				rel = REL_TOUCH;
			end else if (straddles(cb0, cb1) && straddles(ca0, ca1)) begin
				rel = REL_CROSSING;
			end else begin
				rel = REL_DISJOINT;
			end
		end
		r.relation = rel;
		if (rel == REL_TOUCH || rel == REL_OVERLAP)
			r.connected = 1'b1;
		else if (rel == REL_CROSSING)
			r.connected = it.junction_present;
		else
			r.connected = 1'b0;
		return r;
	endfunction

	// ---------------- checking ----------------

	task automatic note_error(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t error: %s", $time, msg);
	endtask

	always @(posedge clk) begin : check_results
		res_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[2:0]);
			result_count++;
			if (pending_results.size() == 0) begin
				note_error($sformatf("result %0d with no pair outstanding, got rel %0d conn %0b",
					result_count, got.relation, got.connected));
			end else begin
				want = pending_results.pop_front();
				if (got.relation !== want.relation)
					note_error($sformatf("result %0d relation expected %0d actual %0d",
						result_count, want.relation, got.relation));
				if (got.connected !== want.connected)
					note_error($sformatf("result %0d connected expected %0b actual %0b",
						result_count, want.connected, got.connected));
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic int rand_offset(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic pair_item_t pair_of(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy, logic j);
		pair_item_t it;
		it = '0;
		it.first_start_x  = coord_t'(ax);
		it.first_start_y  = coord_t'(ay);
		it.first_end_x    = coord_t'(bx);
		it.first_end_y    = coord_t'(by);
		it.second_start_x = coord_t'(cx);
		it.second_start_y = coord_t'(cy);
		it.second_end_x   = coord_t'(dx);
		it.second_end_y   = coord_t'(dy);
		it.junction_present = j;
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_pair(pair_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(classify_segments(it));
		@(negedge clk);
	endtask

	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_WIDTH-1:0] value);
		settle_pipeline();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tol_setting = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- tests ----------------

	task automatic test_directed_cases();
		// reset tolerance of one lsb
		send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_pair(pair_of(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1));
		send_pair(pair_of(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 1'b0));
		send_pair(pair_of(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 1'b1));
		send_pair(pair_of(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 1'b0));
		send_pair(pair_of(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, 1'b1));
		// both points apart, point on and off a segment
		send_pair(pair_of(0, 0, 0, 0, 100, 0, 100, 0, 1'b1));
		send_pair(pair_of(256, 0, 256, 0, 0, 0, 512, 0, 1'b0));
		send_pair(pair_of(256, 10, 256, 10, 0, 0, 512, 0, 1'b1));
		send_pair(pair_of(0, 0, 512, 512, 256, 256, 256, 256, 1'b0));
		// collinear overlap, touch, gap, and a y-dominant overlap
		send_pair(pair_of(0, 0, 1024, 0, 512, 0, 2048, 0, 1'b0));
		send_pair(pair_of(0, 0, 1024, 0, 1024, 0, 2048, 0, 1'b1));
		send_pair(pair_of(0, 0, 1024, 0, 1100, 0, 2048, 0, 1'b1));
		send_pair(pair_of(0, 0, 0, 1024, 0, -512, 0, 512, 1'b0));
		// t junction, crossing, parallel, apart, end just off within tolerance
		send_pair(pair_of(0, 0, 1024, 0, 512, 0, 512, 1024, 1'b0));
		send_pair(pair_of(0, 0, 1024, 1024, 0, 1024, 1024, 0, 1'b1));
		send_pair(pair_of(0, 0, 1024, 1024, 0, 1024, 1024, 0, 1'b0));
		send_pair(pair_of(0, 0, 1024, 0, 0, 100, 1024, 100, 1'b1));
		send_pair(pair_of(0, 0, 100, 100, 200, 0, 300, -50, 1'b1));
		send_pair(pair_of(0, 0, 128, 0, 64, 1, 64, 300, 1'b1));
		write_tolerance('0);
		send_pair(pair_of(0, 0, 0, 0, 1, 0, 1, 0, 1'b1));
		send_pair(pair_of(0, 0, 1, 0, 1, 0, 2, 0, 1'b0));
		write_tolerance('1);
		send_pair(pair_of(0, 0, 0, 0, 60000, 0, 60000, 0, 1'b0));
		send_pair(pair_of(0, 0, 1024, 1024, 0, 1024, 1024, 0, 1'b1));
		send_pair(pair_of(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, 1'b1));
	endtask

	task automatic test_point_pairs(int n);
		int jit, sx, sy, dx, dy, k, px, py, ex, ey;
		for (int i = 0; i < n; i++) begin
			jit = int'(tol_setting) + 2;
			sx = rand_offset(1 << 20);
			sy = rand_offset(1 << 20);
			case ($urandom_range(2))
				0: begin
					px = sx + rand_offset(2 * jit);
					py = sy + rand_offset(2 * jit);
					send_pair(pair_of(sx, sy, sx + rand_offset(jit), sy + rand_offset(jit),
						px, py, px + rand_offset(jit), py + rand_offset(jit),
						rand_bit()));
				end
				default: begin
					dx = rand_offset(1 << 12);
					dy = rand_offset(1 << 12);
					k  = int'($urandom_range(12)) - 2;
					ex = sx + 8 * dx;
					ey = sy + 8 * dy;
					px = sx + k * dx + (($urandom_range(1) == 1) ? rand_offset(2) : 0);
					py = sy + k * dy + (($urandom_range(1) == 1) ? rand_offset(2) : 0);
					if ($urandom_range(1) == 1)
						send_pair(pair_of(px, py, px, py, sx, sy, ex, ey, rand_bit()));
					else
						send_pair(pair_of(sx, sy, ex, ey, px, py, px, py, rand_bit()));
				end
			endcase
		end
	endtask

	task automatic test_collinear_pairs(int n);
		int bx, by, dx, dy, k0, k1, k2, k3, cx, cy;
		for (int i = 0; i < n; i++) begin
			bx = rand_offset(1 << 20);
			by = rand_offset(1 << 20);
			if ($urandom_range(1) == 1) begin
				dx = rand_offset(3);
				dy = rand_offset(3);
			end else begin
				dx = rand_offset(1 << 12);
				dy = rand_offset(1 << 12);
			end
			case ($urandom_range(3))
				0: dy = 0;
				1: dx = 0;
				default: ;
			endcase
			if (dx == 0 && dy == 0)
				dx = 1;
			k0 = int'($urandom_range(12)) - 6;
			k1 = int'($urandom_range(12)) - 6;
			k2 = int'($urandom_range(12)) - 6;
			k3 = int'($urandom_range(12)) - 6;
			cx = bx + k2 * dx;
			cy = by + k2 * dy;
			if ($urandom_range(3) == 0) begin
				cx = cx + rand_offset(int'(tol_setting) + 2);
				cy = cy + rand_offset(int'(tol_setting) + 2);
			end
			send_pair(pair_of(bx + k0 * dx, by + k0 * dy, bx + k1 * dx, by + k1 * dy,
				cx, cy, bx + k3 * dx, by + k3 * dy, rand_bit()));
		end
	endtask

	task automatic test_joined_pairs(int n);
		int ax, ay, bx, by, jx, jy, ox, oy, jit;
		for (int i = 0; i < n; i++) begin
			jit = int'(tol_setting) + 2;
			ax = rand_offset(1 << 16);
			ay = rand_offset(1 << 16);
			bx = rand_offset(1 << 16);
			by = rand_offset(1 << 16);
			case ($urandom_range(2))
				0: begin jx = ax; jy = ay; end
				1: begin jx = bx; jy = by; end
				default: begin jx = (ax + bx) / 2; jy = (ay + by) / 2; end
			endcase
			if ($urandom_range(2) == 0) begin
				jx = jx + rand_offset(jit);
				jy = jy + rand_offset(jit);
			end
			ox = rand_offset(1 << 16);
			oy = rand_offset(1 << 16);
			if ($urandom_range(1) == 1)
				send_pair(pair_of(ax, ay, bx, by, jx, jy, ox, oy, rand_bit()));
			else
				send_pair(pair_of(ax, ay, bx, by, ox, oy, jx, jy, rand_bit()));
		end
	endtask

	task automatic test_free_pairs(int n);
		pair_item_t it;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1) == 1) begin
				it = pair_of(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
					int'($urandom), int'($urandom), int'($urandom), int'($urandom),
					rand_bit());
			end else begin
				it = pair_of(rand_offset(1 << 16), rand_offset(1 << 16),
					rand_offset(1 << 16), rand_offset(1 << 16),
					rand_offset(1 << 16), rand_offset(1 << 16),
					rand_offset(1 << 16), rand_offset(1 << 16), rand_bit());
			end
			send_pair(it);
		end
	endtask

	task automatic test_idle_phase(int send_pct, int stall_pct);
		logic [TOL_WIDTH-1:0] tols [4];
		tols[0] = '0;
		tols[1] = TOL_WIDTH'(1 + $urandom_range(511));
		tols[2] = '1;
		tols[3] = TOL_WIDTH'($urandom_range(65535));
		send_idle_pct  = send_pct;
		sink_stall_pct = stall_pct;
		for (int t = 0; t < 4; t++) begin
			write_tolerance(tols[t]);
			test_point_pairs(25);
			test_collinear_pairs(25);
			test_joined_pairs(25);
			test_free_pairs(25);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_idle_phase(0, 0);
		test_idle_phase(63, 0);
		test_idle_phase(0, 63);
		test_idle_phase(33, 33);
		settle_pipeline();
		repeat (4 * PIPE_LAT) @(posedge clk);
		if (fail_count == 0)
			$display("PASS segment_pair_relation_classifier_unit");
		else
			$display("FAIL segment_pair_relation_classifier_unit");
		$finish;
	end

endmodule
